// ===== sv/assert_macros.svh =====
// Assertion macros shared by the binner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/twsb_pkg.sv =====
// Shared constants and types of the time-weighted sample binner.
package twsb_pkg;
	localparam int MAX_SAMPLES = 64;
	localparam int CNT_W       = 7;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int DIV_STEPS   = 32;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT    = 8'd1;

	localparam logic [15:0]      INTERVAL_RST = 16'd60;
	localparam logic [CNT_W-1:0] COUNT_RST    = 7'd64;

	// divider request: 64-bit dividend, 32-bit divisor
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [31:0] den;
	} div_req_t;

	// divider response: ovf set when the quotient needs more than 32 bits
	typedef struct packed {
		logic        done;
		logic        ovf;
		logic [31:0] quo;
	} div_rsp_t;
endpackage

// ===== sv/twsb_in_if.sv =====
// Reading channel: one beat per timestamped reading.
interface twsb_in_if import twsb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [31:0]        now_s;
	logic signed [31:0] reading;
	logic               reading_finite;

	modport source (output valid, output now_s, output reading, output reading_finite,
		input ready);
	modport sink (input valid, input now_s, input reading, input reading_finite,
		output ready);
endinterface

// ===== sv/twsb_out_if.sv =====
// Result channel: one beat per emitted sample.
interface twsb_out_if import twsb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [31:0] sample_value;
	logic               sample_empty;
	logic               last_of_run;

	modport source (output valid, output sample_value, output sample_empty,
		output last_of_run, input ready);
	modport sink (input valid, input sample_value, input sample_empty,
		input last_of_run, output ready);
endinterface

// ===== sv/twsb_cfg_if.sv =====
// Register write channel: index and data per beat.
interface twsb_cfg_if import twsb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/twsb_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`include "assert_macros.svh"
module twsb_div import twsb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic                 busy_q;
	logic                 done_q;
	logic                 ovf_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [31:0]          rem_q;
	logic [31:0]          quo_q;
	logic [31:0]          den_q;
	logic [33:0]          trial;

	// shifted partial remainder minus divisor; bit 33 is the borrow
	assign trial = {1'b0, rem_q, quo_q[31]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				// high half not below divisor: quotient overflows 32 bits
				if (req.num[63:32] >= req.den) begin
					ovf_q  <= 1'b1;
					done_q <= 1'b1;
				end else begin
					ovf_q  <= 1'b0;
					busy_q <= 1'b1;
					cnt_q  <= DIV_CNT_W'(DIV_STEPS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[63:32];
			quo_q <= req.num[31:0];
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.quo  = quo_q;

	`ASSERT_IMPLIES(a_start_idle, req.start, !busy_q)
	`ASSERT_NEXT(a_done_pulse, rsp.done, !rsp.done)
	`ASSERT_IMPLIES(a_cnt_range, busy_q, (cnt_q != '0) && (cnt_q <= DIV_CNT_W'(DIV_STEPS)))
endmodule

// ===== sv/time_weighted_sample_binner.sv =====
// Top level of the time-weighted sample binner: sequencer and state.
//
// Usage:
//   din  - one beat per reading: now_s (seconds), reading (Q16.16),
//          reading_finite (0 counts the reading as zero).
//   dout - result beats: a run of gap markers (sample_empty=1, value 0)
//          ending in one average beat (sample_empty=0, last_of_run=1).
//   cfg  - register writes, always ready: index 0 sample_interval_s,
//          index 1 sample_count; other indexes are ignored. Write only idle.
// Sequence: the first reading and readings without time advance are handled
//   in the idle state alone. An accumulated reading goes through a multiply
//   step, an accumulate step and a pass of the shared divider for the sample
//   count; if a sample is due, a second divider pass forms the average, then
//   one beat per result at the rate dout takes them.
// din.ready is low after an advancing reading until no sample proves due or
//   the last result beat is taken; a stalled dout holds beat and sequencer.
// Reset: interval 60 s, count 64, no timestamps known, sums cleared.
`include "assert_macros.svh"
module time_weighted_sample_binner import twsb_pkg::*; (
	input logic clk,
	input logic arst_n,
	twsb_cfg_if.sink cfg,
	twsb_in_if.sink din,
	twsb_out_if.source dout
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_DIVR = 3'd3;
	localparam logic [2:0] ST_DIVA = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0]         state_q;
	logic [15:0]        interval_q;
	logic [CNT_W-1:0]   count_q;
	logic               times_known_q;
	logic               sample_known_q;
	logic [31:0]        last_input_q;
	logic [31:0]        last_sample_q;
	logic signed [63:0] sum_q;
	logic [31:0]        wt_q;
	logic [31:0]        now_q;
	logic signed [31:0] val_q;
	logic [31:0]        dt_q;
	logic signed [63:0] prod_q;
	logic [63:0]        mag_q;
	logic [CNT_W-1:0]   runs_q;
	logic [CNT_W-1:0]   left_q;
	logic [31:0]        avg_q;

	logic               in_beat;
	logic               out_beat;
	logic signed [65:0] prod_full;
	logic signed [63:0] acc_sum;
	logic               acc_ovf;
	logic [32:0]        wt_sum;
	logic [15:0]        interval_eff;
	logic [CNT_W-1:0]   cap;
	logic [31:0]        elapsed;
	logic [31:0]        avg_res;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign in_beat  = din.valid && din.ready;
	assign out_beat = dout.valid && dout.ready;

	// register file
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
			count_q    <= COUNT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SAMPLE_INTERVAL: interval_q <= cfg.data;
				REG_SAMPLE_COUNT:    count_q    <= cfg.data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// zero interval acts as 1; count clamps to 1..MAX_SAMPLES
	assign interval_eff = (interval_q == '0) ? 16'd1 : interval_q;
	always_comb begin
		if (count_q == '0)
			cap = CNT_W'(1);
		else if (count_q > CNT_W'(MAX_SAMPLES))
			cap = CNT_W'(MAX_SAMPLES);
		else
			cap = count_q;
	end

	// reading * seconds: exact in 64 bits
	assign prod_full = $signed({val_q[31], val_q}) * $signed({1'b0, dt_q});

	// saturating accumulate
	assign acc_sum = sum_q + prod_q;
	assign acc_ovf = (sum_q[63] == prod_q[63]) && (acc_sum[63] != sum_q[63]);
	assign wt_sum  = {1'b0, wt_q} + {1'b0, dt_q};

	// a fresh sample time gives zero elapsed, so no output this reading
	assign elapsed = sample_known_q ? (now_q - last_sample_q) : 32'd0;

	// divider requests: sample count first, average second
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = {32'd0, elapsed};
		div_req.den   = {16'd0, interval_eff};
		if (state_q == ST_ACC) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_DIVR) begin
			// round half away from zero on the magnitude
			div_req.start = div_rsp.done && (div_rsp.ovf || (div_rsp.quo != '0));
			div_req.num   = mag_q + {33'd0, wt_q[31:1]};
			div_req.den   = wt_q;
		end
	end

	// sign and saturate the quotient to Q16.16
	always_comb begin
		if (sum_q[63]) begin
			if (div_rsp.ovf || (div_rsp.quo > 32'h8000_0000))
				avg_res = 32'h8000_0000;
			else
				avg_res = 32'd0 - div_rsp.quo;
		end else begin
			if (div_rsp.ovf || div_rsp.quo[31])
				avg_res = 32'h7FFF_FFFF;
			else
				avg_res = div_rsp.quo;
		end
	end

	twsb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			times_known_q  <= 1'b0;
			sample_known_q <= 1'b0;
			last_input_q   <= '0;
			last_sample_q  <= '0;
			sum_q          <= '0;
			wt_q           <= '0;
			runs_q         <= '0;
			left_q         <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (!times_known_q) begin
							times_known_q <= 1'b1;
							last_input_q  <= din.now_s;
						end else if (din.now_s > last_input_q) begin
							last_input_q <= din.now_s;
							state_q      <= ST_MUL;
						end
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (acc_ovf)
						sum_q <= sum_q[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
					else
						sum_q <= acc_sum;
					wt_q <= wt_sum[32] ? 32'hFFFF_FFFF : wt_sum[31:0];
					if (!sample_known_q) begin
						sample_known_q <= 1'b1;
						last_sample_q  <= now_q;
					end
					state_q <= ST_DIVR;
				end
				ST_DIVR: begin
					if (div_rsp.done) begin
						if (!div_rsp.ovf && (div_rsp.quo == '0)) begin
							state_q <= ST_IDLE;
						end else begin
							if (div_rsp.ovf || (div_rsp.quo > {25'd0, cap}))
								runs_q <= cap;
							else
								runs_q <= div_rsp.quo[CNT_W-1:0];
							state_q <= ST_DIVA;
						end
					end
				end
				ST_DIVA: begin
					if (div_rsp.done) begin
						left_q        <= runs_q;
						sum_q         <= '0;
						wt_q          <= '0;
						last_sample_q <= now_q;
						state_q       <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_beat) begin
						left_q <= left_q - CNT_W'(1);
						if (left_q == CNT_W'(1))
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_beat) begin
			now_q <= din.now_s;
			val_q <= din.reading_finite ? din.reading : 32'sd0;
			dt_q  <= din.now_s - last_input_q;
		end
		if (state_q == ST_MUL)
			prod_q <= $signed(prod_full[63:0]);
		// magnitude settles while the count divide runs
		if (state_q == ST_DIVR)
			mag_q <= sum_q[63] ? (64'd0 - sum_q) : sum_q;
		if ((state_q == ST_DIVA) && div_rsp.done)
			avg_q <= avg_res;
	end

	assign din.ready         = (state_q == ST_IDLE);
	assign dout.valid        = (state_q == ST_EMIT);
	assign dout.last_of_run  = (left_q == CNT_W'(1));
	assign dout.sample_empty = !dout.last_of_run;
	assign dout.sample_value = dout.last_of_run ? $signed(avg_q) : 32'sd0;

	`ASSERT_IMPLIES(a_left_range, dout.valid, (left_q != '0) && (left_q <= CNT_W'(MAX_SAMPLES)))
	`ASSERT_NEXT(a_last_frees_input, out_beat && dout.last_of_run, din.ready)
	`ASSERT_IMPLIES(a_acc_cleared, dout.valid, (sum_q == '0) && (wt_q == '0))
endmodule

// ===== tb/twsb_sample_checker.sv =====
// Checker for the time-weighted sample binner: watches the channels, predicts and compares.
`timescale 1ns / 100ps
module twsb_sample_checker import twsb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	twsb_cfg_if  cfg,
	twsb_in_if   din,
	twsb_out_if  dout,
	output int   mismatch_count,
	output int   samples_due
);
	typedef struct packed {
		logic signed [31:0] value;
		logic               empty;
		logic               closes;
	} sample_t;

	sample_t due_samples[$];
	sample_t want;
	int      fails;

	// shadow registers and binning state
	logic [15:0]        interval_reg;
	logic [CNT_W-1:0]   count_reg;
	logic               time_seen;
	logic               sample_seen;
	logic [31:0]        last_in_t;
	logic [31:0]        last_sample_t;
	logic signed [63:0] wsum;
	logic [31:0]        wtotal;

	function automatic logic signed [63:0] sum_sat(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		// sign bits disagree: clamp toward the true sign
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	// weighted mean, rounded half away from zero, clamped to Q16.16 range
	function automatic logic [31:0] weighted_mean();
		logic [63:0] mag;
		logic [63:0] q;
		if (wtotal == 32'd0)
			return 32'd0;
		mag = wsum[63] ? ~wsum + 64'd1 : wsum;
		q = (mag + {33'd0, wtotal[31:1]}) / {32'd0, wtotal};
		if (wsum[63]) begin
			if (q > 64'h8000_0000)
				q = 64'h8000_0000;
			return ~q[31:0] + 32'd1;
		end
		if (q > 64'h7FFF_FFFF)
			q = 64'h7FFF_FFFF;
		return q[31:0];
	endfunction

	task automatic bin_reading(input logic [31:0] now, input logic signed [31:0] rd,
		input logic fin);
		logic [31:0]        dt;
		logic [31:0]        ivl;
		logic [31:0]        runs;
		logic [31:0]        cap;
		logic signed [63:0] level;
		logic [32:0]        wnext;
		sample_t            s;
		if (!time_seen) begin
			time_seen = 1'b1;
			last_in_t = now;
			return;
		end
		if (now <= last_in_t)
			return;
		dt = now - last_in_t;
		last_in_t = now;
		level = fin ? {{32{rd[31]}}, rd} : 64'sd0;
		wsum = sum_sat(wsum, level * $signed({32'd0, dt}));
		wnext = {1'b0, wtotal} + {1'b0, dt};
		wtotal = wnext[32] ? 32'hFFFF_FFFF : wnext[31:0];
		if (!sample_seen) begin
			sample_seen = 1'b1;
			last_sample_t = now;
		end
		ivl = (interval_reg == 16'd0) ? 32'd1 : {16'd0, interval_reg};
		runs = (now - last_sample_t) / ivl;
		if (runs == 32'd0)
			return;
		if (count_reg == '0)
			cap = 32'd1;
		else if (count_reg > MAX_SAMPLES)
			cap = MAX_SAMPLES;
		else
			cap = {25'd0, count_reg};
		if (runs > cap)
			runs = cap;
		s.value = '0;
		s.empty = 1'b1;
		s.closes = 1'b0;
		repeat (runs - 32'd1) due_samples = {due_samples, s};
		s.value = weighted_mean();
		s.empty = 1'b0;
		s.closes = 1'b1;
		due_samples = {due_samples, s};
		wsum = '0;
		wtotal = '0;
		last_sample_t = now;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_reg = INTERVAL_RST;
			count_reg = COUNT_RST;
			time_seen = 1'b0;
			sample_seen = 1'b0;
			last_in_t = '0;
			last_sample_t = '0;
			wsum = '0;
			wtotal = '0;
			fails = 0;
			due_samples.delete();
			mismatch_count <= 0;
			samples_due <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_SAMPLE_INTERVAL)
					interval_reg = cfg.data;
				else if (cfg.index == REG_SAMPLE_COUNT)
					count_reg = cfg.data[CNT_W-1:0];
			end
			if (dout.valid && dout.ready) begin
				if (due_samples.size() == 0) begin
					fails++;
					$display("%0t: unexpected result beat: value %0d empty %0b last %0b",
						$time, dout.sample_value, dout.sample_empty, dout.last_of_run);
				end else begin
					want = due_samples.pop_front();
					if (dout.sample_value !== want.value) begin
						fails++;
						$display("%0t: sample_value expected %0d got %0d",
							$time, want.value, dout.sample_value);
					end
					if (dout.sample_empty !== want.empty) begin
						fails++;
						$display("%0t: sample_empty expected %0b got %0b",
							$time, want.empty, dout.sample_empty);
					end
					if (dout.last_of_run !== want.closes) begin
						fails++;
						$display("%0t: last_of_run expected %0b got %0b",
							$time, want.closes, dout.last_of_run);
					end
				end
			end
			if (din.valid && din.ready)
				bin_reading(din.now_s, din.reading, din.reading_finite);
			mismatch_count <= fails;
			samples_due <= due_samples.size();
		end
	end
endmodule

// ===== tb/tb_time_weighted_sample_binner.sv =====
// Testbench top for the time-weighted sample binner: stimulus, pacing, watchdog and verdict.
`timescale 1ns / 100ps
module tb_time_weighted_sample_binner import twsb_pkg::*; ();
	// idle time after the last due sample before touching registers or
	// ending: covers a reading still in the divider that emits nothing
	localparam int SETTLE_CYCLES = 80;
	// cycles with no beat on any channel before the run is declared hung
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_ITEMS = 72;
	// indexes that map to no register, writes must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED     = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_TOP = 8'hFF;

	logic        clk;
	logic        arst_n;
	int          mismatch_count;
	int          samples_due;
	logic [31:0] t_cur;        // latest time the block has taken
	int          burst_left;

	twsb_cfg_if cfg();
	twsb_in_if  din();
	twsb_out_if dout();

	time_weighted_sample_binner uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.din   (din),
		.dout  (dout)
	);

	twsb_sample_checker sample_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.din           (din),
		.dout          (dout),
		.mismatch_count(mismatch_count),
		.samples_due   (samples_due)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Present one reading and hold it until the block takes the beat.
	// valid is left high on purpose: the caller decides whether the next
	// beat follows at once or a gap opens.
	task automatic send_reading(input logic [31:0] t, input logic signed [31:0] v,
		input logic fin);
		din.valid <= 1'b1;
		din.now_s <= t;
		din.reading <= v;
		din.reading_finite <= fin;
		do @(posedge clk); while (!din.ready);
		if (t > t_cur)
			t_cur = t;
	endtask

	// Sender pacing: bursts of random length, then a gap. Short gaps land
	// inside the multiply/accumulate steps, long ones reach into the
	// divider passes and the result beats.
	task automatic pace();
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
		gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 90);
		din.valid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	// Hold the sender until every due sample has come back, then let the
	// block finish any reading that produces no beat.
	task automatic drain();
		din.valid <= 1'b0;
		@(posedge clk);
		while (samples_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes only on an idle block. Unmapped indexes carry random
	// data after each mapped write; if one took effect, a setting would be wrong.
	task automatic configure(input logic [15:0] ivl_data, input logic [15:0] cnt_data);
		logic [CFG_IDX_W-1:0]  idx[4];
		logic [CFG_DATA_W-1:0] val[4];
		drain();
		idx = '{REG_SAMPLE_INTERVAL, REG_UNMAPPED, REG_SAMPLE_COUNT, REG_UNMAPPED_TOP};
		val = '{ivl_data, 16'($urandom), cnt_data, 16'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[i];
			cfg.data <= val[i];
			do @(posedge clk); while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
	endtask

	// One random reading. Steps are scaled to the active interval so most
	// readings land inside a window, some span a few windows and a few
	// span enough to hit the cap. About one in ten repeats or goes back
	// in time and must be dropped.
	task automatic random_reading(input int unsigned ivl);
		logic [31:0]        t;
		logic [63:0]        step;
		logic signed [31:0] v;
		int unsigned        pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			t = t_cur - $urandom_range(0, 3);
		end else begin
			if (pick < 68)
				step = 64'($urandom_range(1, ivl));
			else if (pick < 92)
				step = 64'($urandom_range(ivl, 4 * ivl));
			else
				step = 64'($urandom_range(4 * ivl, 80 * ivl));
			// keep headroom for the closing reading at the top of the time range
			if ({32'd0, t_cur} + step > 64'hF000_0000)
				step = 64'd1;
			t = t_cur + step[31:0];
		end
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			// tiny values: rounding ties show up with short windows
			v = int'($urandom_range(0, 8)) - 4;
		end else if (pick < 20) begin
			case ($urandom_range(0, 3))
				0: v = 32'sh7FFF_FFFF;
				1: v = 32'sh8000_0000;
				2: v = -32'sd1;
				default: v = 32'sd0;
			endcase
		end else begin
			v = $urandom;
		end
		send_reading(t, v, $urandom_range(0, 99) < 85);
		pace();
	endtask

	// Result side: the mode changes at random between always ready, frequent
	// short stalls and rare long ones.
	initial begin
		int unsigned stall_left;
		int unsigned mode_left;
		int unsigned stall_mode;
		stall_left = 0;
		mode_left = 0;
		stall_mode = 0;
		dout.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				stall_left--;
				dout.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(50, 400);
				end
				mode_left--;
				case (stall_mode)
					0: dout.ready <= 1'b1;
					1: begin
						if ($urandom_range(0, 2) == 0) begin
							dout.ready <= 1'b0;
							stall_left = $urandom_range(0, 2);
						end else begin
							dout.ready <= 1'b1;
						end
					end
					default: begin
						if ($urandom_range(0, 15) == 0) begin
							dout.ready <= 1'b0;
							stall_left = $urandom_range(4, 20);
						end else begin
							dout.ready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Watchdog: a hung handshake or a sample that never arrives stops here.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((din.valid && din.ready) || (dout.valid && dout.ready) ||
				(cfg.valid && cfg.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int unsigned ivl;
		arst_n <= 1'b0;
		din.valid <= 1'b0;
		din.now_s <= '0;
		din.reading <= '0;
		din.reading_finite <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= '0;
		cfg.data <= '0;
		t_cur = '0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset settings (60 s windows, cap 64).
		// First reading at time zero: only the time is taken.
		send_reading(32'd0, 32'sh1234_5678, 1'b1);
		// same time again: no advance, dropped
		send_reading(32'd0, 32'sh7FFF_FFFF, 1'b1);
		// first weighted reading: opens the sample window, emits nothing
		send_reading(32'd10, 32'sh7FFF_FFFF, 1'b1);
		// time going backwards: dropped
		send_reading(32'd9, -32'sd5, 1'b1);
		// most negative value, still inside the window
		send_reading(32'd40, 32'sh8000_0000, 1'b1);
		// exactly one window since t=10: a single average beat
		send_reading(32'd70, -32'sd1, 1'b1);
		// non-finite reading weighs in as zero
		send_reading(32'd100, 32'sh7FFF_FFFF, 1'b0);
		// four windows: three gap markers, then the average
		send_reading(32'd310, 32'sh0001_0000, 1'b1);
		// seventy windows: run clipped at the 64-beat cap
		send_reading(32'd4510, 32'sh7FFF_FFFF, 1'b1);
		// step of about 2^31 s with the most negative value
		send_reading(32'h8000_0000, 32'sh8000_0000, 1'b1);
		send_reading(32'h8000_0001, 32'sh7FFF_FFFF, 1'b1);
		send_reading(32'h8000_003C, 32'sh5555_5555, 1'b1);
		// halfway ties: -1.5 LSB must round to -2, +1.5 LSB to +2
		send_reading(32'h8000_005A, 32'sd3, 1'b1);
		send_reading(32'h8000_0078, -32'sd6, 1'b1);
		send_reading(32'h8000_0096, 32'sd5, 1'b1);
		send_reading(32'h8000_00B4, -32'sd2, 1'b1);
		pace();

		// Random phases, each on its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: ivl = 32'(INTERVAL_RST);
				1: begin
					// zero count behaves as a cap of one
					configure(16'd1, 16'd0);
					ivl = 1;
				end
				2: begin
					// zero interval acts as 1 s; count beyond the cap
					configure(16'd0, 16'd127);
					ivl = 1;
				end
				3: begin
					configure(16'hFFFF, 16'd64);
					ivl = 65535;
				end
				4: begin
					configure(16'd7, 16'd3);
					ivl = 7;
				end
				default: begin
					// count data with random upper bits: only the low 7 count
					ivl = $urandom_range(2, 300);
					configure(16'(ivl), 16'($urandom));
				end
			endcase
			repeat (PHASE_ITEMS) begin
				random_reading(ivl);
				if ($urandom_range(0, 39) == 0)
					drain();
			end
		end

		// latest possible time, then the same time again (dropped)
		send_reading(32'hFFFF_FFFF, $urandom, 1'b1);
		send_reading(32'hFFFF_FFFF, $urandom, 1'b1);
		drain();

		if (mismatch_count == 0 && samples_due == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/twsb_pkg.sv
sv/twsb_in_if.sv
sv/twsb_out_if.sv
sv/twsb_cfg_if.sv
sv/twsb_div.sv
sv/time_weighted_sample_binner.sv
tb/twsb_sample_checker.sv
tb/tb_time_weighted_sample_binner.sv
